// ===== rtl/gens_pkg.sv =====
// ----------------------------------------------------------------------------
// gens_pkg
// Shared types and constants of the eight-neighbor sum core.
// ----------------------------------------------------------------------------
package gens_pkg;

  // Fixed field widths of the external interface.
  localparam int CELL_IN_BITS  = 8;
  localparam int SUM_BITS      = 11;
  localparam int INDEX_BITS    = 10;
  localparam int CFG_REG_BITS  = 11;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Register select, taken from paddr[2].
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  // Request kinds on the input channel.
  localparam logic FUNC_CELL  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Which neighbors of the result cell lie inside the grid, and whether it is the last cell.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } pos_flags_t;

  // Position data of one issued request.
  typedef struct packed {
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    logic                  has_out;
    pos_flags_t            flags;
  } item_t;

endpackage

// ===== rtl/grid_eight_neighbor_sum_core.sv =====
// ----------------------------------------------------------------------------
// grid_eight_neighbor_sum_core
// Streaming sum of the eight neighbors of every cell of a raster-scanned grid.
// ----------------------------------------------------------------------------
// Cells enter on the in_ channel in raster order, one request per cell with
// in_func = 0. After the last cell of a frame the source sends column_count+1
// drain requests (in_func = 1) that flush the final row; the last result of
// the frame carries out_last. Requests of the wrong kind for the current
// phase are accepted and dropped without a result.
// Each result belongs to the cell one row plus one cell behind the input.
// Inside the block the request that completes a result is taken into the
// working stage registers, and the result then moves into the out_ register.
// One request per cycle is taken in steady state while out_ready stays high,
// as the line store RAM does one read and one write per cycle.
// When out_ready is low a finished result waits in the out_ register while one
// more request enters the working stage; in_ready then goes low. The user must
// write row_count and column_count over the APB port only while the block is
// idle; the block does not enforce this. A write restarts the frame. Reset sets
// both to at most 8 and starts a new frame; the line stores are not cleared.
// ----------------------------------------------------------------------------
module grid_eight_neighbor_sum_core
  import gens_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int CELL_BITS   = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  logic [CELL_IN_BITS-1:0]  in_cell_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SUM_BITS-1:0]      out_neighbor_sum,
  output logic [INDEX_BITS-1:0]    out_row_index,
  output logic [INDEX_BITS-1:0]    out_column_index,
  output logic                     out_last
);

  localparam int AW = $clog2(MAX_COLUMNS);

  logic                   issue;
  logic [AW-1:0]          issue_addr;
  logic [CELL_BITS-1:0]   issue_cell;
  item_t                  issue_item;
  logic                   ram_wr_en;
  logic [AW-1:0]          ram_wr_addr;
  logic [2*CELL_BITS-1:0] ram_wr_data;
  logic [2*CELL_BITS-1:0] ram_rd_data;

  assign pready = 1'b1;

  gens_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .CELL_BITS   (CELL_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_cell_value (in_cell_value),
    .issue         (issue),
    .issue_addr    (issue_addr),
    .issue_cell    (issue_cell),
    .issue_item    (issue_item)
  );

  // Each entry holds the upper and middle line cells of one column.
  gens_ram #(
    .WIDTH (2 * CELL_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (issue),
    .rd_addr (issue_addr),
    .rd_data (ram_rd_data)
  );

  gens_window #(
    .AW        (AW),
    .CELL_BITS (CELL_BITS)
  ) u_window (
    .clk              (clk),
    .rst_n            (rst_n),
    .issue            (issue),
    .issue_addr       (issue_addr),
    .issue_cell       (issue_cell),
    .issue_item       (issue_item),
    .in_ready         (in_ready),
    .ram_rd_data      (ram_rd_data),
    .ram_wr_en        (ram_wr_en),
    .ram_wr_addr      (ram_wr_addr),
    .ram_wr_data      (ram_wr_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_neighbor_sum (out_neighbor_sum),
    .out_row_index    (out_row_index),
    .out_column_index (out_column_index),
    .out_last         (out_last)
  );

endmodule

// ===== rtl/gens_ram.sv =====
// ----------------------------------------------------------------------------
// gens_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gens_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/gens_ctrl.sv =====
// ----------------------------------------------------------------------------
// gens_ctrl
// Configuration registers, raster position counters and request decode.
// ----------------------------------------------------------------------------
module gens_ctrl
  import gens_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int CELL_BITS   = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [APB_ADDR_BITS-1:0]       paddr,
  input  logic [APB_DATA_BITS-1:0]       pwdata,
  output logic [APB_DATA_BITS-1:0]       prdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_func,
  input  logic [CELL_IN_BITS-1:0]        in_cell_value,
  output logic                           issue,
  output logic [$clog2(MAX_COLUMNS)-1:0] issue_addr,
  output logic [CELL_BITS-1:0]           issue_cell,
  output item_t                          issue_item
);

  localparam int AW  = $clog2(MAX_COLUMNS);
  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int RCW = $clog2(MAX_ROWS);
  localparam int PW  = (RW > CW) ? RW : CW;
  localparam int RESET_ROWS = (MAX_ROWS < 8) ? MAX_ROWS : 8;
  localparam int RESET_COLS = (MAX_COLUMNS < 8) ? MAX_COLUMNS : 8;

  logic [RW-1:0]  rows_r, rows_nxt;
  logic [CW-1:0]  cols_r, cols_nxt;
  logic [RCW-1:0] row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic           drain_r, drain_nxt;

  logic [CFG_REG_BITS-1:0] wval;
  logic                    cfg_wr;
  logic                    accept;
  logic [CW:0]             col_inc;
  logic [RW-1:0]           row_inc;
  logic [PW-1:0]           orow, ocol, rows_m1, cols_m1;
  logic [PW-1:0]           row_w, col_w;
  logic                    has_out;

  assign cfg_wr = psel && penable && pwrite;
  assign wval   = pwdata[CFG_REG_BITS-1:0];
  assign prdata = (paddr[2] == REG_COLUMN_COUNT) ? APB_DATA_BITS'(cols_r)
                                                 : APB_DATA_BITS'(rows_r);

  assign accept = in_valid && in_ready;
  // A drain request counts only while draining, a cell request only otherwise.
  assign issue  = accept && ((in_func == FUNC_DRAIN) == drain_r);

  assign rows_m1 = PW'(rows_r) - PW'(1);
  assign cols_m1 = PW'(cols_r) - PW'(1);
  assign row_w   = PW'(row_r);
  assign col_w   = PW'(col_r);

  always_comb begin
    if (!drain_r) begin
      if (col_r != '0) begin
        has_out = (row_r != '0);
        orow    = row_w - PW'(1);
        ocol    = col_w - PW'(1);
      end else begin
        has_out = (row_w >= PW'(2));
        orow    = row_w - PW'(2);
        ocol    = cols_m1;
      end
    end else begin
      has_out = 1'b1;
      if (col_r == '0) begin
        orow = rows_m1 - PW'(1);
        ocol = cols_m1;
      end else if (col_r < cols_r) begin
        orow = rows_m1;
        ocol = col_w - PW'(1);
      end else begin
        orow = rows_m1;
        ocol = cols_m1;
      end
    end
  end

  always_comb begin
    issue_item.row          = INDEX_BITS'(orow);
    issue_item.col          = INDEX_BITS'(ocol);
    issue_item.has_out      = has_out;
    issue_item.flags.top    = (orow != '0);
    issue_item.flags.bottom = (orow < rows_m1);
    issue_item.flags.left   = (ocol != '0);
    issue_item.flags.right  = (ocol < cols_m1);
    issue_item.flags.last   = (orow == rows_m1) && (ocol == cols_m1);
    issue_addr = (drain_r && (col_r >= cols_r)) ? '0 : col_r[AW-1:0];
    issue_cell = drain_r ? '0 : CELL_BITS'(in_cell_value);
  end

  assign col_inc = {1'b0, col_r} + (CW+1)'(1);
  assign row_inc = RW'(row_r) + RW'(1);

  always_comb begin
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    drain_nxt = drain_r;
    if (cfg_wr) begin
      // Out-of-range values are clamped; any write restarts the frame.
      if (paddr[2] == REG_ROW_COUNT) begin
        if (wval < CFG_REG_BITS'(2)) begin
          rows_nxt = RW'(2);
        end else if (32'(wval) > MAX_ROWS) begin
          rows_nxt = RW'(MAX_ROWS);
        end else begin
          rows_nxt = RW'(wval);
        end
      end else begin
        if (wval < CFG_REG_BITS'(2)) begin
          cols_nxt = CW'(2);
        end else if (32'(wval) > MAX_COLUMNS) begin
          cols_nxt = CW'(MAX_COLUMNS);
        end else begin
          cols_nxt = CW'(wval);
        end
      end
      row_nxt   = '0;
      col_nxt   = '0;
      drain_nxt = 1'b0;
    end else if (issue) begin
      if (!drain_r) begin
        if (col_inc >= (CW+1)'(cols_r)) begin
          col_nxt = '0;
          if (row_inc >= rows_r) begin
            row_nxt   = '0;
            drain_nxt = 1'b1;
          end else begin
            row_nxt = row_inc[RCW-1:0];
          end
        end else begin
          col_nxt = col_inc[CW-1:0];
        end
      end else begin
        if (col_inc > (CW+1)'(cols_r)) begin
          col_nxt   = '0;
          drain_nxt = 1'b0;
        end else begin
          col_nxt = col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= RW'(RESET_ROWS);
      cols_r  <= CW'(RESET_COLS);
      row_r   <= '0;
      col_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      rows_r  <= rows_nxt;
      cols_r  <= cols_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ===== rtl/gens_window.sv =====
// ----------------------------------------------------------------------------
// gens_window
// Line store update, 3x3 window, masked neighbor sum and result register.
// ----------------------------------------------------------------------------
module gens_window
  import gens_pkg::*;
#(
  parameter int AW        = 10,
  parameter int CELL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    issue,
  input  logic [AW-1:0]           issue_addr,
  input  logic [CELL_BITS-1:0]    issue_cell,
  input  item_t                   issue_item,
  output logic                    in_ready,
  input  logic [2*CELL_BITS-1:0]  ram_rd_data,
  output logic                    ram_wr_en,
  output logic [AW-1:0]           ram_wr_addr,
  output logic [2*CELL_BITS-1:0]  ram_wr_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SUM_BITS-1:0]     out_neighbor_sum,
  output logic [INDEX_BITS-1:0]   out_row_index,
  output logic [INDEX_BITS-1:0]   out_column_index,
  output logic                    out_last
);

  localparam int SW = CELL_BITS + 3;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [AW-1:0]          s1_addr_r;
  logic [CELL_BITS-1:0]   s1_cell_r;
  item_t                  s1_item_r;
  logic                   s1_fwd_r;
  logic [2*CELL_BITS-1:0] wr_pair_r;
  logic [CELL_BITS-1:0]   win_r [9];
  logic [CELL_BITS-1:0]   win_nxt [9];
  logic                   out_valid_r, out_valid_nxt;
  logic [SUM_BITS-1:0]    sum_r;
  logic [INDEX_BITS-1:0]  row_r, col_r;
  logic                   last_r;

  logic                   s1_adv;
  logic [2*CELL_BITS-1:0] pair;
  logic [CELL_BITS-1:0]   upper_cell, middle_cell;
  logic [SW-1:0]          sum;

  assign s1_adv   = s1_valid_r && (!s1_item_r.has_out || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // The RAM reads before it writes, so a read of the column written in the
  // same cycle takes the pair from the bypass register instead.
  assign pair        = s1_fwd_r ? wr_pair_r : ram_rd_data;
  assign upper_cell  = pair[2*CELL_BITS-1:CELL_BITS];
  assign middle_cell = pair[CELL_BITS-1:0];

  assign ram_wr_en   = s1_adv;
  assign ram_wr_addr = s1_addr_r;
  assign ram_wr_data = {middle_cell, s1_cell_r};

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = upper_cell;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = middle_cell;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_cell_r;
  end

  always_comb begin
    pos_flags_t f;
    f   = s1_item_r.flags;
    sum = '0;
    if (f.top) begin
      sum = sum + SW'(win_nxt[1]);
    end
    if (f.top && f.left) begin
      sum = sum + SW'(win_nxt[0]);
    end
    if (f.top && f.right) begin
      sum = sum + SW'(win_nxt[2]);
    end
    if (f.left) begin
      sum = sum + SW'(win_nxt[3]);
    end
    if (f.right) begin
      sum = sum + SW'(win_nxt[5]);
    end
    if (f.bottom) begin
      sum = sum + SW'(win_nxt[7]);
    end
    if (f.bottom && f.left) begin
      sum = sum + SW'(win_nxt[6]);
    end
    if (f.bottom && f.right) begin
      sum = sum + SW'(win_nxt[8]);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_item_r.has_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      s1_fwd_r    <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (issue) begin
        s1_fwd_r <= s1_adv && (s1_addr_r == issue_addr);
      end
      if (s1_adv) begin
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_addr_r <= issue_addr;
      s1_cell_r <= issue_cell;
      s1_item_r <= issue_item;
    end
    if (s1_adv) begin
      wr_pair_r <= ram_wr_data;
    end
    if (s1_adv && s1_item_r.has_out) begin
      sum_r  <= SUM_BITS'(sum);
      row_r  <= s1_item_r.row;
      col_r  <= s1_item_r.col;
      last_r <= s1_item_r.flags.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_neighbor_sum = sum_r;
  assign out_row_index    = row_r;
  assign out_column_index = col_r;
  assign out_last         = last_r;

endmodule
